/* design/hsa_pkg.sv */
package hsa_pkg;

  localparam int WORD_W = 32;
  localparam int BIT_W  = $clog2(WORD_W);

  localparam int LIN_W  = 26;
  localparam int NUM_W  = 27;

  localparam int X_MUL = 1000;
  localparam int Y_MUL = 10;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef struct packed {
    logic [WORD_W-1:0] set;
    logic [WORD_W-1:0] clr;
  } hsa_edit_t;

endpackage

/* design/hashed_slot_allocator.sv */
// Linear-probing slot allocator. The used bitmap sits in a ring of 32-bit
// cells that rotates by one cell every clock, so each word passes the head
// of the ring in turn; reset clears the ring at once and there is no
// clearing pass. An allocate word is first hashed (the coordinate sum, an
// offset by a multiple of the pool size that makes it non-negative, a
// reciprocal multiply and a subtract to reduce it modulo the pool size, the
// scale multiply, a second multiply and subtract, a handover), then waits
// for its start word to reach the head and scans up to NWORDS more words,
// one word per cycle. A full output register can hold the result back.
// One word is handled at a time; the next is taken while the previous
// result waits in the output register.
module hashed_slot_allocator #(
  parameter int POOL_SIZE = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              cmd,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [15:0] pos_z,
  input  logic [7:0]        scale,
  input  logic [9:0]        free_index,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [9:0]        slot,
  output logic              ok
);
  import hsa_pkg::*;

  localparam int NWORDS    = (POOL_SIZE + WORD_W - 1) / WORD_W;
  localparam int IDX_W     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int H_W       = IDX_W + BIT_W;
  localparam int LAST_BITS = POOL_SIZE - (NWORDS - 1) * WORD_W;
  localparam int CW        = (IDX_W > 5) ? IDX_W : 5;
  localparam logic [63:0]       LAST_FULL = (64'd1 << LAST_BITS) - 64'd1;
  localparam logic [WORD_W-1:0] LAST_MASK = LAST_FULL[WORD_W-1:0];
  localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(NWORDS - 1);
  localparam logic [16:0]       POOL_CMP  = 17'(POOL_SIZE);

  typedef enum logic [5:0] {
    T_IDLE = 6'b000001,
    T_HASH = 6'b000010,
    T_SEEK = 6'b000100,
    T_SCAN = 6'b001000,
    T_FREE = 6'b010000,
    T_DONE = 6'b100000
  } top_state_t;

  function automatic logic [BIT_W-1:0] lowest_bit(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] p;
    p = '0;
    for (int k = WORD_W - 1; k >= 0; k--) begin
      if (v[k]) p = BIT_W'(k);
    end
    return p;
  endfunction

  top_state_t        state;
  logic              go;
  logic signed [15:0] pos_x_r;
  logic signed [15:0] pos_y_r;
  logic signed [15:0] pos_z_r;
  logic [7:0]        scale_r;
  logic [9:0]        free_index_r;
  logic [9:0]        res_slot;
  logic              res_ok;
  logic [IDX_W-1:0]  head_idx;

  logic              hash_done;
  logic [H_W-1:0]    hash_h;
  logic [WORD_W-1:0] ring [NWORDS];
  logic [WORD_W-1:0] head_word;
  hsa_edit_t         edit;

  logic [IDX_W-1:0]  start_word;
  logic [BIT_W-1:0]  start_bit;
  logic              at_start;
  logic              at_free;
  logic [WORD_W-1:0] pool_mask;
  logic [WORD_W-1:0] ge_mask;
  logic [WORD_W-1:0] scan_mask;
  logic [WORD_W-1:0] free_bits;
  logic              found;
  logic [BIT_W-1:0]  found_pos;
  logic [H_W+9:0]    slot_ext;
  logic [BIT_W-1:0]  free_bit;
  logic              free_hit;
  logic              can_out;

  hsa_hash #(
    .POOL_SIZE (POOL_SIZE),
    .H_W       (H_W)
  ) u_hash (
    .clk   (clk),
    .rst   (rst),
    .go    (go),
    .pos_x (pos_x_r),
    .pos_y (pos_y_r),
    .pos_z (pos_z_r),
    .scale (scale_r),
    .done  (hash_done),
    .h     (hash_h)
  );

  // bitmap ring: cell 0 is the head, the edited head word re-enters at the tail
  for (genvar i = 0; i < NWORDS; i++) begin : g_cell
    if (i == NWORDS - 1) begin : g_tail
      hsa_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .word_in  (ring[0]),
        .edit     (edit),
        .word_out (ring[i])
      );
    end else begin : g_body
      hsa_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .word_in  (ring[i+1]),
        .edit     ('0),
        .word_out (ring[i])
      );
    end
  end

  assign head_word  = ring[0];
  assign start_word = hash_h[H_W-1:BIT_W];
  assign start_bit  = hash_h[BIT_W-1:0];
  assign at_start   = (head_idx == start_word);
  assign at_free    = (CW'(head_idx) == CW'(free_index_r[9:5]));
  assign free_bit   = free_index_r[4:0];
  assign free_hit   = head_word[free_bit];
  assign pool_mask  = (head_idx == IDX_LAST) ? LAST_MASK : '1;
  assign ge_mask    = {WORD_W{1'b1}} << start_bit;
  assign scan_mask  = (state == T_SEEK) ? ge_mask : (at_start ? ~ge_mask : '1);
  assign free_bits  = ~head_word & scan_mask & pool_mask;
  assign found      = |free_bits;
  assign found_pos  = lowest_bit(free_bits);
  assign slot_ext   = {10'd0, head_idx, found_pos};
  assign can_out    = !out_valid || out_ready;
  assign in_ready   = (state == T_IDLE);

  always_comb begin
    edit = '0;
    if ((state == T_SEEK && at_start && found) || (state == T_SCAN && found)) begin
      edit.set = WORD_W'(1) << found_pos;
    end
    if (state == T_FREE && at_free && free_hit) begin
      edit.clr = WORD_W'(1) << free_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_idx <= '0;
    end else begin
      head_idx <= (head_idx == IDX_LAST) ? '0 : head_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      go <= 1'b0;
    end else begin
      go <= (state == T_IDLE) && in_valid && (cmd == CMD_ALLOC);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == T_DONE && can_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
    end else begin
      case (state)
        T_IDLE: begin
          if (in_valid) begin
            if (cmd == CMD_ALLOC) begin
              state <= T_HASH;
            end else if (17'(free_index) >= POOL_CMP) begin
              state <= T_DONE;
            end else begin
              state <= T_FREE;
            end
          end
        end
        T_HASH: begin
          if (hash_done) begin
            state <= T_SEEK;
          end
        end
        T_SEEK: begin
          if (at_start) begin
            state <= found ? T_DONE : T_SCAN;
          end
        end
        T_SCAN: begin
          if (found || at_start) begin
            state <= T_DONE;
          end
        end
        T_FREE: begin
          if (at_free) begin
            state <= T_DONE;
          end
        end
        T_DONE: begin
          if (can_out) begin
            state <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      T_IDLE: begin
        if (in_valid) begin
          pos_x_r      <= pos_x;
          pos_y_r      <= pos_y;
          pos_z_r      <= pos_z;
          scale_r      <= scale;
          free_index_r <= free_index;
          res_slot     <= '0;
          res_ok       <= 1'b0;
        end
      end
      T_SEEK, T_SCAN: begin
        if (found && (state == T_SCAN || at_start)) begin
          res_slot <= slot_ext[9:0];
          res_ok   <= 1'b1;
        end
      end
      T_FREE: begin
        if (at_free) begin
          res_ok <= free_hit;
        end
      end
      T_DONE: begin
        if (can_out) begin
          slot <= res_slot;
          ok   <= res_ok;
        end
      end
      default: begin
      end
    endcase
  end

  a_rise_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == T_DONE))
    else $error("result word raised outside completion");

  a_single_edit: assert property (@(posedge clk) disable iff (rst)
    $onehot0(edit.set | edit.clr))
    else $error("more than one bitmap bit edited");

  a_claim_free: assert property (@(posedge clk) disable iff (rst)
    (edit.set != '0) |-> ((head_word & edit.set) == '0))
    else $error("claimed slot already in use");

  a_hash_when_waiting: assert property (@(posedge clk) disable iff (rst)
    hash_done |-> (state == T_HASH))
    else $error("hash finished with no allocate waiting");

endmodule

/* design/hsa_cell.sv */
module hsa_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [hsa_pkg::WORD_W-1:0] word_in,
  input  hsa_pkg::hsa_edit_t         edit,
  output logic [hsa_pkg::WORD_W-1:0] word_out
);
  import hsa_pkg::*;

  logic [WORD_W-1:0] word;

  always_ff @(posedge clk) begin
    if (rst) begin
      word <= '0;
    end else begin
      word <= (word_in & ~edit.clr) | edit.set;
    end
  end

  assign word_out = word;

endmodule

/* design/hsa_hash.sv */
module hsa_hash #(
  parameter int POOL_SIZE = 1024,
  parameter int H_W       = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [15:0] pos_z,
  input  logic [7:0]        scale,
  output logic              done,
  output logic [H_W-1:0]    h
);
  import hsa_pkg::*;

  localparam int POOL_L  = $clog2(POOL_SIZE);
  localparam int SHIFT   = NUM_W + POOL_L;
  localparam int RECIP_W = NUM_W + 1;
  localparam int QP_W    = NUM_W + RECIP_W;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(POOL_SIZE) - 64'd1) / 64'(POOL_SIZE);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
  localparam int OFF_MULT = ((1 << (LIN_W - 1)) + POOL_SIZE - 1) / POOL_SIZE;
  localparam logic [NUM_W-1:0] OFF    = NUM_W'(OFF_MULT * POOL_SIZE);
  localparam logic [NUM_W-1:0] POOL_N = NUM_W'(POOL_SIZE);

  typedef enum logic [7:0] {
    H_IDLE = 8'b00000001,
    H_OFF  = 8'b00000010,
    H_QA   = 8'b00000100,
    H_RA   = 8'b00001000,
    H_MUL  = 8'b00010000,
    H_QB   = 8'b00100000,
    H_RB   = 8'b01000000,
    H_DONE = 8'b10000000
  } hash_state_t;

  hash_state_t              state;
  logic signed [LIN_W-1:0]  lin;
  logic [NUM_W-1:0]         num;
  logic [NUM_W-1:0]         quo;
  logic [H_W-1:0]           rem;
  logic [QP_W-1:0]          q_prod;
  logic [NUM_W-1:0]         q_back;
  logic [NUM_W-1:0]         diff;

  // remainder by reciprocal multiply, exact for any value below 2^NUM_W
  assign q_prod = QP_W'(num) * QP_W'(RECIP);
  assign q_back = quo * POOL_N;
  assign diff   = num - q_back;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= H_IDLE;
    end else begin
      case (state)
        H_IDLE: begin
          if (go) begin
            state <= H_OFF;
          end
        end
        H_OFF:   state <= H_QA;
        H_QA:    state <= H_RA;
        H_RA:    state <= H_MUL;
        H_MUL:   state <= H_QB;
        H_QB:    state <= H_RB;
        H_RB:    state <= H_DONE;
        H_DONE:  state <= H_IDLE;
        default: state <= H_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      H_IDLE: begin
        lin <= LIN_W'(pos_x) * LIN_W'(X_MUL) + LIN_W'(pos_y) * LIN_W'(Y_MUL)
               + LIN_W'(pos_z);
      end
      H_OFF: begin
        // a multiple of the pool size keeps the sum non-negative
        num <= NUM_W'(lin) + OFF;
      end
      H_QA, H_QB: begin
        quo <= NUM_W'(q_prod >> SHIFT);
      end
      H_RA, H_RB: begin
        rem <= diff[H_W-1:0];
      end
      H_MUL: begin
        num <= NUM_W'(scale) * NUM_W'(rem);
      end
      default: begin
      end
    endcase
  end

  assign done = (state == H_DONE);
  assign h    = rem;

endmodule

/* verif/hashed_slot_allocator_tb.sv */
module hashed_slot_allocator_tb;
  import hsa_pkg::*;

  localparam int  POOL        = 1024;
  localparam int  CYCLE_LIMIT = 1500000;
  localparam int  TAIL_CYCLES = 120;

  typedef struct {
    logic [9:0] slot;
    logic       ok;
  } grant_t;

  logic               clk        = 1'b0;
  logic               rst        = 1'b1;
  logic               in_valid   = 1'b0;
  logic               in_ready;
  logic               cmd        = CMD_ALLOC;
  logic signed [15:0] pos_x      = '0;
  logic signed [15:0] pos_y      = '0;
  logic signed [15:0] pos_z      = '0;
  logic [7:0]         scale      = '0;
  logic [9:0]         free_index = '0;
  logic               out_valid;
  logic               out_ready  = 1'b0;
  logic [9:0]         slot;
  logic               ok;

  logic [POOL-1:0] slot_map = '0;
  grant_t          pending_grants[$];
  int              errors       = 0;
  int              cycle_count  = 0;
  int              tx_idle_pct  = 0;
  int              rx_stall_pct = 0;
  logic            hold_on      = 1'b0;

  hashed_slot_allocator #(.POOL_SIZE(POOL)) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z),
    .scale      (scale),
    .free_index (free_index),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .slot       (slot),
    .ok         (ok)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("hashed_slot_allocator: mismatch");
      $finish;
    end
  end

  // receiver side, long hold-off overrides random stalling
  always @(posedge clk) begin
    if (hold_on) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  function automatic logic [9:0] hash_start(logic signed [15:0] x, logic signed [15:0] y,
                                           logic signed [15:0] z, logic [7:0] s);
    longint v;
    longint r;
    v = longint'(s) * (longint'(x) * 1000 + longint'(y) * 10 + longint'(z));
    r = v % longint'(POOL);
    if (r < 0) begin
      r += POOL;
    end
    return r[9:0];
  endfunction

  function automatic grant_t predict_word(logic c, logic signed [15:0] x,
                                          logic signed [15:0] y, logic signed [15:0] z,
                                          logic [7:0] s, logic [9:0] fi);
    grant_t g;
    int     idx;
    g.slot = '0;
    g.ok   = 1'b0;
    if (c == CMD_ALLOC) begin
      idx = int'(hash_start(x, y, z, s));
      for (int n = 0; n < POOL; n++) begin
        if (!slot_map[idx[9:0]]) begin
          slot_map[idx[9:0]] = 1'b1;
          g.slot = idx[9:0];
          g.ok   = 1'b1;
          break;
        end
        idx = (idx + 1) % POOL;
      end
    end else if (int'(fi) < POOL && slot_map[fi]) begin
      slot_map[fi] = 1'b0;
      g.ok = 1'b1;
    end
    return g;
  endfunction

  always @(posedge clk) begin : result_check
    grant_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_grants.size() == 0) begin
        $error("unexpected word: slot %0d ok %0d", slot, ok);
        errors++;
      end else begin
        want = pending_grants.pop_front();
        if (slot !== want.slot) begin
          $error("slot: expected %0d actual %0d", want.slot, slot);
          errors++;
        end
        if (ok !== want.ok) begin
          $error("ok: expected %0d actual %0d", want.ok, ok);
          errors++;
        end
      end
    end
  end

  task automatic send_word(logic c, logic signed [15:0] x, logic signed [15:0] y,
                           logic signed [15:0] z, logic [7:0] s, logic [9:0] fi);
    int gap;
    in_valid   <= 1'b1;
    cmd        <= c;
    pos_x      <= x;
    pos_y      <= y;
    pos_z      <= z;
    scale      <= s;
    free_index <= fi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_grants.push_back(predict_word(c, x, y, z, s, fi));
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_grants.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(9))
      0, 1, 2: return 16'($urandom);
      3, 4, 5: return 16'($urandom_range(8) - 4);
      6:       return 16'sh7fff;
      7:       return -16'sh8000;
      8:       return -16'sd1;
      default: return 16'($urandom_range(200) - 100);
    endcase
  endfunction

  function automatic logic [7:0] rand_scale();
    case ($urandom_range(5))
      0:       return 8'd0;
      1:       return 8'd255;
      2, 3:    return 8'($urandom_range(4));
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic test_extremes();
    send_word(CMD_ALLOC, 16'sd0, 16'sd0, 16'sd0, 8'd0, 10'd0);
    send_word(CMD_ALLOC, 16'sh7fff, 16'sh7fff, 16'sh7fff, 8'd255, 10'h3ff);
    send_word(CMD_ALLOC, -16'sh8000, -16'sh8000, -16'sh8000, 8'd255, 10'd0);
    send_word(CMD_ALLOC, -16'sd1, 16'sd0, 16'sd0, 8'd1, 10'h2aa);
    send_word(CMD_ALLOC, 16'sd0, 16'sd0, 16'sd0, 8'd0, 10'h155);
    send_word(CMD_ALLOC, 16'sd0, 16'sd0, -16'sd1, 8'd255, 10'd0);
    send_word(CMD_ALLOC, 16'sh7fff, -16'sh8000, 16'sd0, 8'd128, 10'd0);
    send_word(CMD_ALLOC, 16'sh1234, -16'sh4321, 16'sh0f0f, 8'd0, 10'h3ff);
  endtask

  task automatic test_free_cases();
    send_word(CMD_FREE, 16'sh7fff, -16'sh8000, 16'sh5555, 8'd255, 10'd0);
    send_word(CMD_FREE, 16'sd0, 16'sd0, 16'sd0, 8'd0, 10'd0);
    send_word(CMD_FREE, -16'sd1, -16'sd1, -16'sd1, 8'd170, 10'h3ff);
    // probe wrapping from the last slot
    send_word(CMD_ALLOC, 16'sd0, 16'sd0, -16'sd1, 8'd1, 10'd0);
    send_word(CMD_ALLOC, 16'sd0, 16'sd0, -16'sd1, 8'd1, 10'd0);
    send_word(CMD_FREE, 16'sd0, 16'sd0, 16'sd0, 8'd0, 10'h3ff);
    send_word(CMD_FREE, 16'sd0, 16'sd0, 16'sd0, 8'd0, 10'h3ff);
    send_word(CMD_FREE, 16'sd0, 16'sd0, 16'sd0, 8'd0, 10'd1);
    send_word(CMD_ALLOC, 16'sd3, 16'sd3, 16'sd3, 8'd0, 10'd0);
    send_word(CMD_FREE, 16'sd0, 16'sd0, 16'sd0, 8'd0, 10'h200);
  endtask

  task automatic test_random(int n, int idle_pct, int stall_pct);
    logic [9:0] fi;
    int         start;
    int         pick;
    tx_idle_pct  = idle_pct;
    rx_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 52) begin
        send_word(CMD_ALLOC, rand_coord(), rand_coord(), rand_coord(), rand_scale(),
                  10'($urandom));
      end else begin
        fi = 10'($urandom);
        if ($urandom_range(3) != 0) begin
          start = int'($urandom_range(POOL - 1));
          for (int k = 0; k < POOL; k++) begin
            pick = (start + k) % POOL;
            if (slot_map[pick[9:0]]) begin
              fi = pick[9:0];
              break;
            end
          end
        end
        send_word(CMD_FREE, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom), fi);
      end
    end
  endtask

  task automatic test_backpressure();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    fork
      begin
        hold_on <= 1'b1;
        repeat (400) @(posedge clk);
        hold_on <= 1'b0;
      end
    join_none
    for (int i = 0; i < 24; i++) begin
      send_word(i[0] ? CMD_FREE : CMD_ALLOC, rand_coord(), rand_coord(), rand_coord(),
                rand_scale(), 10'($urandom_range(POOL - 1)));
    end
    wait_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_free_cases();
    wait_drained();
    test_random(200, 0, 0);
    test_random(150, 87, 0);
    test_random(150, 0, 87);
    // pause the sender until every word is back
    wait_drained();
    test_random(150, 22, 22);
    test_backpressure();
    test_random(60, 22, 22);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("hashed_slot_allocator: match");
    end else begin
      $display("hashed_slot_allocator: mismatch");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/hsa_pkg.sv
design/hsa_cell.sv
design/hsa_hash.sv
design/hashed_slot_allocator.sv
verif/hashed_slot_allocator_tb.sv
